@@ hw/rtl/afgc_pkg.sv @@
// Shared types, codes and constants for the ALE frame grammar checker.
package afgc_pkg;

    localparam int unsigned TypeWidth    = 4;
    localparam int unsigned CharWidth    = 7;
    localparam int unsigned VerdictWidth = 4;
    localparam int unsigned CountWidth   = 6;
    localparam int unsigned RunWidth     = 4;
    localparam int unsigned RunLimWidth  = 3;
    localparam int unsigned ExtWidth     = 2;
    localparam int unsigned AddrWidth    = 4;
    localparam int unsigned DataWidth    = 32;

    // preamble codes
    localparam logic [TypeWidth-1:0] W_DATA = 4'd0;
    localparam logic [TypeWidth-1:0] W_THRU = 4'd1;
    localparam logic [TypeWidth-1:0] W_TO   = 4'd2;
    localparam logic [TypeWidth-1:0] W_TWAS = 4'd3;
    localparam logic [TypeWidth-1:0] W_FROM = 4'd4;
    localparam logic [TypeWidth-1:0] W_TIS  = 4'd5;
    localparam logic [TypeWidth-1:0] W_CMD  = 4'd6;
    localparam logic [TypeWidth-1:0] W_REP  = 4'd7;

    // verdict / error codes
    localparam logic [VerdictWidth-1:0] V_OK            = 4'd0;
    localparam logic [VerdictWidth-1:0] V_EMPTY         = 4'd1;
    localparam logic [VerdictWidth-1:0] V_TIS_TWAS      = 4'd2;
    localparam logic [VerdictWidth-1:0] V_CMD_COUNT     = 4'd3;
    localparam logic [VerdictWidth-1:0] V_PAYLOAD       = 4'd4;
    localparam logic [VerdictWidth-1:0] V_NO_ANCHOR     = 4'd5;
    localparam logic [VerdictWidth-1:0] V_RUN_LONG      = 4'd6;
    localparam logic [VerdictWidth-1:0] V_STUFFING      = 4'd7;
    localparam logic [VerdictWidth-1:0] V_DATA_DATA     = 4'd8;
    localparam logic [VerdictWidth-1:0] V_REP_CONCLUDED = 4'd9;

    // last extension codes
    localparam logic [ExtWidth-1:0] EXT_NONE = 2'd0;
    localparam logic [ExtWidth-1:0] EXT_DATA = 2'd1;
    localparam logic [ExtWidth-1:0] EXT_REP  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_RUN_LIMIT     = 2'd0;
    localparam logic [1:0] REG_CMD_LIMIT     = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

    localparam logic [RunLimWidth-1:0] RUN_LIMIT_RESET     = 3'd5;
    localparam logic [CountWidth-1:0]  CMD_LIMIT_RESET     = 6'd30;
    localparam logic [CountWidth-1:0]  PAYLOAD_LIMIT_RESET = 6'd29;

    localparam logic [CharWidth-1:0] CH_AT = 7'h40;
    localparam logic [CharWidth-1:0] CH_D  = 7'h44;
    localparam logic [CharWidth-1:0] CH_T  = 7'h54;
    localparam logic [CharWidth-1:0] CH_B  = 7'h42;
    localparam logic [CharWidth-1:0] CH_M  = 7'h4D;

    typedef struct packed {
        logic                 word_present;
        logic [TypeWidth-1:0] word_type;
        logic [CharWidth-1:0] first_char;
        logic [CharWidth-1:0] second_char;
        logic [CharWidth-1:0] third_char;
        logic                 frame_end;
    } word_t;

    typedef struct packed {
        logic [RunLimWidth-1:0] address_run_limit;
        logic [CountWidth-1:0]  command_word_limit;
        logic [CountWidth-1:0]  payload_word_limit;
    } cfg_t;

endpackage

@@ hw/rtl/afgc_if.sv @@
// Valid/ready channel interfaces for frame words and verdicts.
interface afgc_word_if;
    logic                                valid;
    logic                                ready;
    logic                                word_present;
    logic [afgc_pkg::TypeWidth-1:0]      word_type;
    logic [afgc_pkg::CharWidth-1:0]      first_char;
    logic [afgc_pkg::CharWidth-1:0]      second_char;
    logic [afgc_pkg::CharWidth-1:0]      third_char;
    logic                                frame_end;

    modport source (output valid, word_present, word_type, first_char, second_char,
                    third_char, frame_end, input ready);
    modport sink (input valid, word_present, word_type, first_char, second_char,
                  third_char, frame_end, output ready);
endinterface

interface afgc_verdict_if;
    logic                                valid;
    logic                                ready;
    logic [afgc_pkg::VerdictWidth-1:0]   verdict;

    modport source (output valid, verdict, input ready);
    modport sink (input valid, verdict, output ready);
endinterface

@@ hw/rtl/afgc_cfg_regs.sv @@
// APB register file holding the three grammar limits.
module afgc_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afgc_pkg::AddrWidth-1:0]    paddr,
    input  logic [afgc_pkg::DataWidth-1:0]    pwdata,
    output logic [afgc_pkg::DataWidth-1:0]    prdata,
    output logic                              pready,
    output afgc_pkg::cfg_t                    cfg
);

    afgc_pkg::cfg_t cfg_reg;
    afgc_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                afgc_pkg::REG_RUN_LIMIT:
                    cfg_next.address_run_limit = pwdata[afgc_pkg::RunLimWidth-1:0];
                afgc_pkg::REG_CMD_LIMIT:
                    cfg_next.command_word_limit = pwdata[afgc_pkg::CountWidth-1:0];
                afgc_pkg::REG_PAYLOAD_LIMIT:
                    cfg_next.payload_word_limit = pwdata[afgc_pkg::CountWidth-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_run_limit  <= afgc_pkg::RUN_LIMIT_RESET;
            cfg_reg.command_word_limit <= afgc_pkg::CMD_LIMIT_RESET;
            cfg_reg.payload_word_limit <= afgc_pkg::PAYLOAD_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            afgc_pkg::REG_RUN_LIMIT:
                prdata = {{(afgc_pkg::DataWidth-afgc_pkg::RunLimWidth){1'b0}},
                          cfg_reg.address_run_limit};
            afgc_pkg::REG_CMD_LIMIT:
                prdata = {{(afgc_pkg::DataWidth-afgc_pkg::CountWidth){1'b0}},
                          cfg_reg.command_word_limit};
            afgc_pkg::REG_PAYLOAD_LIMIT:
                prdata = {{(afgc_pkg::DataWidth-afgc_pkg::CountWidth){1'b0}},
                          cfg_reg.payload_word_limit};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/afgc_core.sv @@
// Frame state registers and combinational grammar check per word.
module afgc_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  afgc_pkg::word_t                      item,
    input  afgc_pkg::cfg_t                       cfg,
    output logic [afgc_pkg::VerdictWidth-1:0]    verdict
);

    logic                                in_msg_reg,     in_msg_next;
    logic [afgc_pkg::CountWidth-1:0]     cmd_count_reg,  cmd_count_next;
    logic [afgc_pkg::CountWidth-1:0]     pay_count_reg,  pay_count_next;
    logic                                pay_exempt_reg, pay_exempt_next;
    logic                                concl_reg,      concl_next;
    logic [afgc_pkg::RunWidth-1:0]       run_len_reg,    run_len_next;
    logic [afgc_pkg::ExtWidth-1:0]       prev_ext_reg,   prev_ext_next;
    logic                                stuffed_reg,    stuffed_next;
    logic                                saw_tis_reg,    saw_tis_next;
    logic                                saw_twas_reg,   saw_twas_next;
    logic                                saw_word_reg,   saw_word_next;
    logic [afgc_pkg::VerdictWidth-1:0]   first_err_reg,  first_err_next;

    logic [afgc_pkg::CountWidth-1:0]     cmd_inc;
    logic [afgc_pkg::CountWidth-1:0]     pay_inc;
    logic [afgc_pkg::RunWidth-1:0]       run_inc;
    logic                                has_at;
    logic                                is_dtm_dbm;
    logic                                is_data;

    assign cmd_inc = (&cmd_count_reg) ? cmd_count_reg : cmd_count_reg + 1'b1;
    assign pay_inc = (&pay_count_reg) ? pay_count_reg : pay_count_reg + 1'b1;
    assign run_inc = (&run_len_reg) ? run_len_reg : run_len_reg + 1'b1;
    assign has_at  = (item.first_char == afgc_pkg::CH_AT) ||
                     (item.second_char == afgc_pkg::CH_AT) ||
                     (item.third_char == afgc_pkg::CH_AT);
    assign is_dtm_dbm = (item.first_char == afgc_pkg::CH_D) &&
                        (item.third_char == afgc_pkg::CH_M) &&
                        ((item.second_char == afgc_pkg::CH_T) ||
                         (item.second_char == afgc_pkg::CH_B));
    assign is_data = (item.word_type == afgc_pkg::W_DATA);

    always_comb
    begin
        in_msg_next     = in_msg_reg;
        cmd_count_next  = cmd_count_reg;
        pay_count_next  = pay_count_reg;
        pay_exempt_next = pay_exempt_reg;
        concl_next      = concl_reg;
        run_len_next    = run_len_reg;
        prev_ext_next   = prev_ext_reg;
        stuffed_next    = stuffed_reg;
        saw_tis_next    = saw_tis_reg;
        saw_twas_next   = saw_twas_reg;
        saw_word_next   = saw_word_reg;
        first_err_next  = first_err_reg;

        if (item.word_present)
        begin
            saw_word_next = 1'b1;
            if (item.word_type == afgc_pkg::W_TIS)
            begin
                saw_tis_next = 1'b1;
            end
            if (item.word_type == afgc_pkg::W_TWAS)
            begin
                saw_twas_next = 1'b1;
            end
            if (first_err_reg == afgc_pkg::V_OK)
            begin
                case (item.word_type)
                    afgc_pkg::W_TO, afgc_pkg::W_THRU, afgc_pkg::W_FROM,
                    afgc_pkg::W_TIS, afgc_pkg::W_TWAS:
                    begin
                        in_msg_next   = 1'b0;
                        pay_count_next = '0;
                        concl_next    = (item.word_type == afgc_pkg::W_TIS) ||
                                        (item.word_type == afgc_pkg::W_TWAS);
                        run_len_next  = afgc_pkg::RunWidth'(1);
                        prev_ext_next = afgc_pkg::EXT_NONE;
                        stuffed_next  = 1'b0;
                    end
                    afgc_pkg::W_CMD:
                    begin
                        in_msg_next    = 1'b1;
                        cmd_count_next = cmd_inc;
                        if (cmd_inc > cfg.command_word_limit)
                        begin
                            first_err_next = afgc_pkg::V_CMD_COUNT;
                        end
                        else
                        begin
                            pay_count_next  = '0;
                            pay_exempt_next = is_dtm_dbm;
                        end
                    end
                    afgc_pkg::W_DATA, afgc_pkg::W_REP:
                    begin
                        if (in_msg_reg)
                        begin
                            pay_count_next = pay_inc;
                            if (!pay_exempt_reg && (pay_inc > cfg.payload_word_limit))
                            begin
                                first_err_next = afgc_pkg::V_PAYLOAD;
                            end
                        end
                        else if (run_len_reg == '0)
                        begin
                            first_err_next = afgc_pkg::V_NO_ANCHOR;
                        end
                        else
                        begin
                            run_len_next = run_inc;
                            if (run_inc > {1'b0, cfg.address_run_limit})
                            begin
                                first_err_next = afgc_pkg::V_RUN_LONG;
                            end
                            else if (stuffed_reg)
                            begin
                                first_err_next = afgc_pkg::V_STUFFING;
                            end
                            else
                            begin
                                stuffed_next = has_at;
                                if (is_data && (prev_ext_reg == afgc_pkg::EXT_DATA))
                                begin
                                    first_err_next = afgc_pkg::V_DATA_DATA;
                                end
                                else if ((prev_ext_reg == afgc_pkg::EXT_NONE) &&
                                         concl_reg && !is_data)
                                begin
                                    first_err_next = afgc_pkg::V_REP_CONCLUDED;
                                end
                                else
                                begin
                                    prev_ext_next = is_data ? afgc_pkg::EXT_DATA
                                                            : afgc_pkg::EXT_REP;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        first_err_next = first_err_reg;
                    end
                endcase
            end
        end

        if (!saw_word_next)
        begin
            verdict = afgc_pkg::V_EMPTY;
        end
        else if (saw_tis_next && saw_twas_next)
        begin
            verdict = afgc_pkg::V_TIS_TWAS;
        end
        else
        begin
            verdict = first_err_next;
        end

        if (item.frame_end)
        begin
            in_msg_next     = 1'b0;
            cmd_count_next  = '0;
            pay_count_next  = '0;
            pay_exempt_next = 1'b0;
            concl_next      = 1'b0;
            run_len_next    = '0;
            prev_ext_next   = afgc_pkg::EXT_NONE;
            stuffed_next    = 1'b0;
            saw_tis_next    = 1'b0;
            saw_twas_next   = 1'b0;
            saw_word_next   = 1'b0;
            first_err_next  = afgc_pkg::V_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg     <= 1'b0;
            cmd_count_reg  <= '0;
            pay_count_reg  <= '0;
            pay_exempt_reg <= 1'b0;
            concl_reg      <= 1'b0;
            run_len_reg    <= '0;
            prev_ext_reg   <= afgc_pkg::EXT_NONE;
            stuffed_reg    <= 1'b0;
            saw_tis_reg    <= 1'b0;
            saw_twas_reg   <= 1'b0;
            saw_word_reg   <= 1'b0;
            first_err_reg  <= afgc_pkg::V_OK;
        end
        else if (fire)
        begin
            in_msg_reg     <= in_msg_next;
            cmd_count_reg  <= cmd_count_next;
            pay_count_reg  <= pay_count_next;
            pay_exempt_reg <= pay_exempt_next;
            concl_reg      <= concl_next;
            run_len_reg    <= run_len_next;
            prev_ext_reg   <= prev_ext_next;
            stuffed_reg    <= stuffed_next;
            saw_tis_reg    <= saw_tis_next;
            saw_twas_reg   <= saw_twas_next;
            saw_word_reg   <= saw_word_next;
            first_err_reg  <= first_err_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.frame_end |=> !saw_word_reg && (first_err_reg == afgc_pkg::V_OK)
                                   && (run_len_reg == '0) && (cmd_count_reg == '0))
        else $error("frame state not cleared after frame end");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.frame_end && (first_err_reg != afgc_pkg::V_OK)
        |=> first_err_reg == $past(first_err_reg))
        else $error("first error overwritten within a frame");

    a_anchor_before_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_ext_reg != afgc_pkg::EXT_NONE) |-> (run_len_reg != '0))
        else $error("extension recorded without an anchor");

endmodule

@@ hw/rtl/ale_frame_grammar_checker.sv @@
// Top level of the ALE frame grammar checker: input register, core, verdict register.
//
//  channel   dir  kind           payload
//  words     in   valid/ready    word_present, word_type, three chars, frame_end
//  verdicts  out  valid/ready    verdict (one per frame, on the closing word)
//  apb       in   APB write/read address_run_limit, command_word_limit, payload_word_limit
//
// One word per cycle while no stalled verdict holds the input; a word is taken into the input register first.
// A verdict is loaded into the verdict register when the closing word leaves the input register.
// A stalled verdict holds only the closing word; other words keep flowing.
// rst_n clears the frame state and restores the limits 5 / 30 / 29.
module ale_frame_grammar_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [afgc_pkg::AddrWidth-1:0]    paddr,
    input  logic [afgc_pkg::DataWidth-1:0]    pwdata,
    output logic [afgc_pkg::DataWidth-1:0]    prdata,
    output logic                              pready,
    afgc_word_if.sink                         words,
    afgc_verdict_if.source                    verdicts
);

    afgc_pkg::cfg_t                      cfg;
    afgc_pkg::word_t                     item_reg;
    logic                                item_vld_reg;
    logic                                out_vld_reg;
    logic [afgc_pkg::VerdictWidth-1:0]   out_verdict_reg;
    logic [afgc_pkg::VerdictWidth-1:0]   verdict;
    logic                                out_free;
    logic                                fire;
    logic                                take;

    afgc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free    = !out_vld_reg || verdicts.ready;
    assign fire        = item_vld_reg && (!item_reg.frame_end || out_free);
    assign words.ready = !item_vld_reg || fire;
    assign take        = words.valid && words.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= take || (item_vld_reg && !fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.word_present <= words.word_present;
            item_reg.word_type    <= words.word_type;
            item_reg.first_char   <= words.first_char;
            item_reg.second_char  <= words.second_char;
            item_reg.third_char   <= words.third_char;
            item_reg.frame_end    <= words.frame_end;
        end
    end

    afgc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && item_reg.frame_end)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (verdicts.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item_reg.frame_end)
        begin
            out_verdict_reg <= verdict;
        end
    end

    assign verdicts.valid   = out_vld_reg;
    assign verdicts.verdict = out_verdict_reg;

    a_ready_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !words.ready |-> item_vld_reg && item_reg.frame_end && out_vld_reg)
        else $error("input stalled without a pending verdict");

    a_verdict_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(fire && item_reg.frame_end))
        else $error("verdict without a closing word");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_verdict_reg <= afgc_pkg::V_REP_CONCLUDED)
        else $error("verdict code out of range");

endmodule

@@ verif/ale_frame_grammar_checker_tb.sv @@
// Self-checking testbench for the ALE frame grammar checker: word stimulus, verdict prediction.
`timescale 1ns / 100ps

module ale_frame_grammar_checker_tb;

    localparam logic [afgc_pkg::TypeWidth-1:0] W_UNKNOWN_LO = 4'd8;
    localparam logic [afgc_pkg::TypeWidth-1:0] W_UNKNOWN_HI = 4'd15;
    localparam int WordBits = $bits(afgc_pkg::word_t);

    class frame_verdict_tracker;
        logic [afgc_pkg::RunLimWidth-1:0]  run_lim;
        logic [afgc_pkg::CountWidth-1:0]   cmd_lim;
        logic [afgc_pkg::CountWidth-1:0]   pay_lim;
        bit                                in_msg;
        bit                                exempt;
        bit                                concluded;
        bit                                stuffed;
        bit                                saw_tis;
        bit                                saw_twas;
        bit                                saw_word;
        logic [afgc_pkg::CountWidth-1:0]   cmd_cnt;
        logic [afgc_pkg::CountWidth-1:0]   pay_cnt;
        logic [afgc_pkg::RunWidth-1:0]     run_len;
        logic [afgc_pkg::ExtWidth-1:0]     prev_ext;
        logic [afgc_pkg::VerdictWidth-1:0] first_err;
        logic [afgc_pkg::VerdictWidth-1:0] verdicts_due[$];
        int                                faults;

        function new();
            run_lim = afgc_pkg::RUN_LIMIT_RESET;
            cmd_lim = afgc_pkg::CMD_LIMIT_RESET;
            pay_lim = afgc_pkg::PAYLOAD_LIMIT_RESET;
            faults  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            in_msg    = 1'b0;
            exempt    = 1'b0;
            concluded = 1'b0;
            stuffed   = 1'b0;
            saw_tis   = 1'b0;
            saw_twas  = 1'b0;
            saw_word  = 1'b0;
            cmd_cnt   = '0;
            pay_cnt   = '0;
            run_len   = '0;
            prev_ext  = afgc_pkg::EXT_NONE;
            first_err = afgc_pkg::V_OK;
        endfunction

        function void flag(string what, int want, int got);
            if (faults < 10)
                $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
            faults++;
        endfunction

        function void grammar_step(afgc_pkg::word_t w);
            saw_word = 1'b1;
            if (w.word_type == afgc_pkg::W_TIS)
                saw_tis = 1'b1;
            if (w.word_type == afgc_pkg::W_TWAS)
                saw_twas = 1'b1;
            if (first_err != afgc_pkg::V_OK)
                return;
            case (w.word_type)
                afgc_pkg::W_TO, afgc_pkg::W_THRU, afgc_pkg::W_FROM,
                afgc_pkg::W_TIS, afgc_pkg::W_TWAS:
                begin
                    in_msg    = 1'b0;
                    pay_cnt   = '0;
                    concluded = (w.word_type == afgc_pkg::W_TIS ||
                                 w.word_type == afgc_pkg::W_TWAS);
                    run_len   = afgc_pkg::RunWidth'(1);
                    prev_ext  = afgc_pkg::EXT_NONE;
                    stuffed   = 1'b0;
                end
                afgc_pkg::W_CMD:
                begin
                    in_msg = 1'b1;
                    if (cmd_cnt != '1)
                        cmd_cnt++;
                    if (cmd_cnt > cmd_lim)
                    begin
                        first_err = afgc_pkg::V_CMD_COUNT;
                        return;
                    end
                    pay_cnt = '0;
                    exempt  = w.first_char == afgc_pkg::CH_D &&
                              w.third_char == afgc_pkg::CH_M &&
                              (w.second_char == afgc_pkg::CH_T ||
                               w.second_char == afgc_pkg::CH_B);
                end
                afgc_pkg::W_DATA, afgc_pkg::W_REP:
                begin
                    if (in_msg)
                    begin
                        if (pay_cnt != '1)
                            pay_cnt++;
                        if (!exempt && pay_cnt > pay_lim)
                            first_err = afgc_pkg::V_PAYLOAD;
                        return;
                    end
                    if (run_len == 0)
                    begin
                        first_err = afgc_pkg::V_NO_ANCHOR;
                        return;
                    end
                    if (run_len != '1)
                        run_len++;
                    if (run_len > run_lim)
                    begin
                        first_err = afgc_pkg::V_RUN_LONG;
                        return;
                    end
                    if (stuffed)
                    begin
                        first_err = afgc_pkg::V_STUFFING;
                        return;
                    end
                    if (w.first_char == afgc_pkg::CH_AT || w.second_char == afgc_pkg::CH_AT ||
                        w.third_char == afgc_pkg::CH_AT)
                        stuffed = 1'b1;
                    if (w.word_type == afgc_pkg::W_DATA && prev_ext == afgc_pkg::EXT_DATA)
                    begin
                        first_err = afgc_pkg::V_DATA_DATA;
                        return;
                    end
                    if (prev_ext == afgc_pkg::EXT_NONE && concluded &&
                        w.word_type == afgc_pkg::W_REP)
                    begin
                        first_err = afgc_pkg::V_REP_CONCLUDED;
                        return;
                    end
                    prev_ext = (w.word_type == afgc_pkg::W_DATA) ? afgc_pkg::EXT_DATA
                                                                 : afgc_pkg::EXT_REP;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void take_word(afgc_pkg::word_t w);
            logic [afgc_pkg::VerdictWidth-1:0] v;
            if (w.word_present)
                grammar_step(w);
            if (w.frame_end)
            begin
                if (!saw_word)
                    v = afgc_pkg::V_EMPTY;
                else if (saw_tis && saw_twas)
                    v = afgc_pkg::V_TIS_TWAS;
                else
                    v = first_err;
                verdicts_due.insert(verdicts_due.size(), v);
                clear_frame();
            end
        endfunction

        function void match_verdict(logic [afgc_pkg::VerdictWidth-1:0] got);
            logic [afgc_pkg::VerdictWidth-1:0] want;
            if (verdicts_due.size() == 0)
            begin
                flag("verdict with no frame closed", -1, got);
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want)
                flag("verdict", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [afgc_pkg::AddrWidth-1:0] paddr;
    logic [afgc_pkg::DataWidth-1:0] pwdata;
    logic [afgc_pkg::DataWidth-1:0] prdata;
    logic pready;

    afgc_word_if    words_if();
    afgc_verdict_if verdicts_if();

    frame_verdict_tracker sb;
    afgc_pkg::word_t frame_q[$];
    bit    quiet;
    int    words_sent;

    ale_frame_grammar_checker i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .words    (words_if),
        .verdicts (verdicts_if)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        verdicts_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            verdicts_if.ready = quiet || $urandom_range(0, 99) >= 10;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdicts_if.valid && verdicts_if.ready)
            sb.match_verdict(verdicts_if.verdict);
    end

    function automatic afgc_pkg::word_t mk(input logic [afgc_pkg::TypeWidth-1:0] t,
                                           input logic [afgc_pkg::CharWidth-1:0] a,
                                           input logic [afgc_pkg::CharWidth-1:0] b,
                                           input logic [afgc_pkg::CharWidth-1:0] c);
        afgc_pkg::word_t w;
        w              = '0;
        w.word_present = 1'b1;
        w.word_type    = t;
        w.first_char   = a;
        w.second_char  = b;
        w.third_char   = c;
        return w;
    endfunction

    function automatic logic [afgc_pkg::CharWidth-1:0] plain_char();
        int c;
        c = $urandom_range(0, 126);
        if (c >= afgc_pkg::CH_AT)
            c++;
        return c[afgc_pkg::CharWidth-1:0];
    endfunction

    function automatic logic [afgc_pkg::CharWidth-1:0] any_char();
        return afgc_pkg::CharWidth'($urandom_range(0, 127));
    endfunction

    function automatic logic [afgc_pkg::TypeWidth-1:0] ext_type();
        return $urandom_range(0, 1) ? afgc_pkg::W_DATA : afgc_pkg::W_REP;
    endfunction

    function automatic void add_word(input afgc_pkg::word_t w);
        frame_q.insert(frame_q.size(), w);
    endfunction

    task automatic push_word(input afgc_pkg::word_t w);
        while (!quiet && $urandom_range(0, 99) < 10)
        begin
            words_if.valid = 1'b0;
            @(negedge clk);
        end
        words_if.valid        = 1'b1;
        words_if.word_present = w.word_present;
        words_if.word_type    = w.word_type;
        words_if.first_char   = w.first_char;
        words_if.second_char  = w.second_char;
        words_if.third_char   = w.third_char;
        words_if.frame_end    = w.frame_end;
        @(posedge clk);
        while (!words_if.ready)
            @(posedge clk);
        sb.take_word(w);
        if (w.word_present || w.frame_end)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        afgc_pkg::word_t ignored;
        foreach (frame_q[i])
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                ignored              = WordBits'($urandom());
                ignored.word_present = 1'b0;
                ignored.frame_end    = 1'b0;
                push_word(ignored);
            end
            push_word(frame_q[i]);
        end
    endtask

    task automatic send_closed();
        afgc_pkg::word_t w;
        w = '0;
        if (frame_q.size() == 0)
            add_word(w);
        frame_q[$].frame_end = 1'b1;
        send_frame();
        frame_q.delete();
    endtask

    task automatic close_random();
        afgc_pkg::word_t w;
        if ($urandom_range(0, 1))
        begin
            frame_q[$].frame_end = 1'b1;
        end
        else
        begin
            w              = WordBits'($urandom());
            w.word_present = 1'b0;
            w.frame_end    = 1'b1;
            add_word(w);
        end
    endtask

    task automatic drain();
        words_if.valid = 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [afgc_pkg::DataWidth-1:0] d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = d;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [afgc_pkg::DataWidth-1:0] d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        d = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_limits(input logic [afgc_pkg::RunLimWidth-1:0] r,
                                  input logic [afgc_pkg::CountWidth-1:0] c,
                                  input logic [afgc_pkg::CountWidth-1:0] p);
        logic [afgc_pkg::DataWidth-1:0] d;
        d = $urandom();
        d[afgc_pkg::RunLimWidth-1:0] = r;
        apb_write(afgc_pkg::REG_RUN_LIMIT, d);
        d = $urandom();
        d[afgc_pkg::CountWidth-1:0] = c;
        apb_write(afgc_pkg::REG_CMD_LIMIT, d);
        d = $urandom();
        d[afgc_pkg::CountWidth-1:0] = p;
        apb_write(afgc_pkg::REG_PAYLOAD_LIMIT, d);
        sb.run_lim = r;
        sb.cmd_lim = c;
        sb.pay_lim = p;
        apb_read(afgc_pkg::REG_RUN_LIMIT, d);
        if (d[afgc_pkg::RunLimWidth-1:0] !== r)
            sb.flag("run limit readback", r, d[afgc_pkg::RunLimWidth-1:0]);
        apb_read(afgc_pkg::REG_CMD_LIMIT, d);
        if (d[afgc_pkg::CountWidth-1:0] !== c)
            sb.flag("command limit readback", c, d[afgc_pkg::CountWidth-1:0]);
        apb_read(afgc_pkg::REG_PAYLOAD_LIMIT, d);
        if (d[afgc_pkg::CountWidth-1:0] !== p)
            sb.flag("payload limit readback", p, d[afgc_pkg::CountWidth-1:0]);
    endtask

    task automatic directed_frames();
        send_closed();
        add_word(mk(afgc_pkg::W_TO, 7'h7F, 7'h7F, 7'h7F));
        send_closed();
        add_word(mk(afgc_pkg::W_DATA, 7'h00, 7'h00, 7'h00));
        send_closed();
        add_word(mk(afgc_pkg::W_DATA, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_TIS, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_TWAS, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_TIS, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_REP, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_FROM, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_DATA, plain_char(), plain_char(), afgc_pkg::CH_AT));
        add_word(mk(afgc_pkg::W_REP, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_THRU, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_DATA, plain_char(), plain_char(), plain_char()));
        add_word(mk(afgc_pkg::W_DATA, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_TO, plain_char(), plain_char(), plain_char()));
        repeat (5)
        begin
            add_word(mk(frame_q.size() % 2 ? afgc_pkg::W_DATA : afgc_pkg::W_REP,
                        plain_char(), plain_char(), plain_char()));
        end
        send_closed();
        add_word(mk(afgc_pkg::W_CMD, afgc_pkg::CH_D, afgc_pkg::CH_B, afgc_pkg::CH_M));
        add_word(mk(afgc_pkg::W_REP, afgc_pkg::CH_AT, afgc_pkg::CH_AT, afgc_pkg::CH_AT));
        add_word(mk(W_UNKNOWN_LO, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(W_UNKNOWN_HI, 7'h7F, 7'h7F, 7'h7F));
        add_word('0);
        add_word('0);
        send_closed();
    endtask

    task automatic build_good_frame();
        int n;
        int cmds;
        int lim;
        bit is_concl;
        bit dtm;
        logic [afgc_pkg::TypeWidth-1:0] concl;
        logic [afgc_pkg::TypeWidth-1:0] t;
        logic [afgc_pkg::ExtWidth-1:0] last;
        afgc_pkg::word_t w;
        frame_q.delete();
        cmds  = 0;
        concl = $urandom_range(0, 1) ? afgc_pkg::W_TIS : afgc_pkg::W_TWAS;
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 2) == 0 && cmds < sb.cmd_lim)
            begin
                cmds++;
                dtm = $urandom_range(0, 2) == 0;
                if (dtm)
                    w = mk(afgc_pkg::W_CMD, afgc_pkg::CH_D,
                           $urandom_range(0, 1) ? afgc_pkg::CH_T : afgc_pkg::CH_B,
                           afgc_pkg::CH_M);
                else
                    w = mk(afgc_pkg::W_CMD, plain_char(), plain_char(), plain_char());
                add_word(w);
                lim = sb.pay_lim;
                if ($urandom_range(0, 9) == 0)
                    n = lim + (dtm ? 2 : 0);
                else
                    n = $urandom_range(0, lim < 6 ? lim : 6);
                repeat (n)
                    add_word(mk(ext_type(), any_char(), any_char(), any_char()));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: t = afgc_pkg::W_TO;
                    1: t = afgc_pkg::W_THRU;
                    2: t = afgc_pkg::W_FROM;
                    default: t = concl;
                endcase
                is_concl = (t == afgc_pkg::W_TIS || t == afgc_pkg::W_TWAS);
                add_word(mk(t, plain_char(), plain_char(), plain_char()));
                n    = (sb.run_lim == 0) ? 0 : $urandom_range(0, sb.run_lim - 1);
                last = afgc_pkg::EXT_NONE;
                for (int i = 0; i < n; i++)
                begin
                    if (last == afgc_pkg::EXT_DATA)
                        t = afgc_pkg::W_REP;
                    else if (last == afgc_pkg::EXT_NONE && is_concl)
                        t = afgc_pkg::W_DATA;
                    else
                        t = ext_type();
                    w = mk(t, plain_char(), plain_char(), plain_char());
                    if (i == n - 1 && $urandom_range(0, 2) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0: w.first_char = afgc_pkg::CH_AT;
                            1: w.second_char = afgc_pkg::CH_AT;
                            default: w.third_char = afgc_pkg::CH_AT;
                        endcase
                    end
                    add_word(w);
                    last = (t == afgc_pkg::W_DATA) ? afgc_pkg::EXT_DATA : afgc_pkg::EXT_REP;
                end
            end
        end
    endtask

    task automatic build_noise_frame();
        afgc_pkg::word_t w;
        frame_q.delete();
        repeat ($urandom_range(1, 6))
        begin
            w              = WordBits'($urandom());
            w.word_present = $urandom_range(0, 9) != 0;
            w.frame_end    = 1'b0;
            add_word(w);
        end
    endtask

    task automatic run_random(input int n_words);
        int stop;
        int k;
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            k = $urandom_range(0, 9);
            if (k < 9)
                build_good_frame();
            else
                build_noise_frame();
            if (k == 7 || k == 8)
            begin
                k = $urandom_range(0, frame_q.size() - 1);
                if ($urandom_range(0, 1))
                begin
                    frame_q[k].word_type = afgc_pkg::TypeWidth'($urandom_range(0, 15));
                end
                else
                begin
                    frame_q.insert(k, frame_q[k]);
                    frame_q[k].word_type = afgc_pkg::TypeWidth'($urandom_range(0, 7));
                end
            end
            close_random();
            send_frame();
            frame_q.delete();
            if ($urandom_range(0, 39) == 0)
                drain();
        end
        drain();
    endtask

    // counters run into saturation or two past the limit
    task automatic long_frames();
        repeat (sb.cmd_lim + 2)
            add_word(mk(afgc_pkg::W_CMD, plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_CMD, plain_char(), plain_char(), plain_char()));
        repeat (sb.pay_lim + 2)
            add_word(mk(ext_type(), plain_char(), plain_char(), plain_char()));
        send_closed();
        add_word(mk(afgc_pkg::W_CMD, afgc_pkg::CH_D, afgc_pkg::CH_T, afgc_pkg::CH_M));
        repeat (66)
            add_word(mk(ext_type(), plain_char(), plain_char(), plain_char()));
        send_closed();
        drain();
    endtask

    initial
    begin
        sb                    = new();
        quiet                 = 1'b0;
        words_sent            = 0;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        words_if.valid        = 1'b0;
        words_if.word_present = 1'b0;
        words_if.word_type    = '0;
        words_if.first_char   = '0;
        words_if.second_char  = '0;
        words_if.third_char   = '0;
        words_if.frame_end    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_frames();
        drain();
        run_random(180);

        program_limits(3'd7, 6'd62, 6'd62);
        long_frames();
        run_random(180);

        program_limits(3'd1, 6'd1, 6'd1);
        run_random(180);

        program_limits(3'd0, 6'd0, 6'd0);
        run_random(150);

        quiet = 1'b1;
        program_limits(3'd7, 6'd63, 6'd63);
        long_frames();
        run_random(180);
        quiet = 1'b0;

        program_limits(3'd3, 6'd2, 6'd3);
        run_random(180);

        program_limits(afgc_pkg::RunLimWidth'($urandom_range(1, 7)),
                       afgc_pkg::CountWidth'($urandom_range(1, 8)),
                       afgc_pkg::CountWidth'($urandom_range(1, 8)));
        run_random(180);

        program_limits(afgc_pkg::RUN_LIMIT_RESET, afgc_pkg::CMD_LIMIT_RESET,
                       afgc_pkg::PAYLOAD_LIMIT_RESET);
        run_random(180);

        repeat (10) @(posedge clk);
        if (sb.faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
